>>> rtl/core/led_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the line edit buffer.
// No dependencies; used by every module in rtl/core.
package led_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned BYTE_W   = 8;

  localparam logic [BYTE_W-1:0] BAR_BYTE = 8'h7C;
  localparam logic [BYTE_W-1:0] NL_BYTE  = 8'h0A;

  localparam logic [2:0] CMD_LEFT      = 3'd0;
  localparam logic [2:0] CMD_RIGHT     = 3'd1;
  localparam logic [2:0] CMD_TYPE      = 3'd2;
  localparam logic [2:0] CMD_BACKSPACE = 3'd3;
  localparam logic [2:0] CMD_HOME      = 3'd4;
  localparam logic [2:0] CMD_END       = 3'd5;
  localparam logic [2:0] CMD_PRINT     = 3'd6;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [7:0]        step;
    logic [BYTE_W-1:0] char_in;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic [POS_W-1:0]  cursor_now;
    logic [POS_W-1:0]  length_now;
    logic              full_flag;
  } rsp_t;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } chain_op_e;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LEFT,
    SEL_RIGHT,
    SEL_LOAD
  } cell_sel_e;

  typedef struct packed {
    chain_op_e         op;
    logic [POS_W-1:0]  cursor;
    logic [POS_W-1:0]  len;
    logic [BYTE_W-1:0] ch;
  } chain_ctrl_t;

endpackage

>>> rtl/core/line_edit_buffer.sv
`timescale 1ns / 1ps
// Line edit buffer top level: command decode, cursor and length registers,
// print sequencer. Depends on led_pkg and led_chain.
//
// Usage: a request is taken at a rising edge where start is high and busy
// is low. Its fields are the command, a step count for cursor moves and a
// byte for type. Results leave on rsp_o, each marked by a one-cycle
// valid_o strobe; the receiver must take every result as it comes.
// Left, right, type, backspace, home, end and the unused code give one
// result, registered, in the cycle after the request; busy stays low, so a
// new request may follow every cycle. The text lives in a row of byte
// cells whose moving bytes all shift in the same cycle. Print raises busy
// and streams length + 2 bytes (the text with a bar at the cursor, then a
// newline marked last), one per cycle through the rsp_o register; busy
// drops as the newline is registered. The stream rotates the cell row
// once around the text, leaving it as it was. Reset clears cursor,
// length, sequencer and result register; the cell bytes are left as they
// are, since only written bytes are ever read.
module line_edit_buffer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  led_pkg::req_t req_i,
  output logic          valid_o,
  output led_pkg::rsp_t rsp_o
);
  import led_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_PRINT
  } state_e;

  localparam logic [POS_W-1:0] CapPos = POS_W'(CAPACITY);

  state_e           state_d, state_q;
  logic [POS_W-1:0] cursor_d, cursor_q;
  logic [POS_W-1:0] len_d, len_q;
  logic [POS_W-1:0] pos_d, pos_q;     // Next text index to be printed.
  logic             bar_d, bar_q;     // Bar byte already printed.
  logic             valid_d, valid_q;
  rsp_t             rsp_d, rsp_q;

  chain_ctrl_t       chain_ctrl;
  logic [BYTE_W-1:0] head_byte;
  logic              accept;
  logic [POS_W-1:0]  dist_to_end;

  assign accept      = start && (state_q == ST_IDLE);
  assign dist_to_end = len_q - cursor_q;

  led_chain u_chain (
    .clk_i  (clk_i),
    .ctrl_i (chain_ctrl),
    .head_o (head_byte)
  );

  always_comb begin
    state_d  = state_q;
    cursor_d = cursor_q;
    len_d    = len_q;
    pos_d    = pos_q;
    bar_d    = bar_q;
    valid_d  = 1'b0;
    rsp_d    = rsp_q;

    chain_ctrl.op     = OP_NOP;
    chain_ctrl.cursor = cursor_q;
    chain_ctrl.len    = len_q;
    chain_ctrl.ch     = req_i.char_in;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rsp_d.full_flag = 1'b0;
          unique case (req_i.cmd)
            CMD_LEFT: begin
              cursor_d = (req_i.step >= {2'b00, cursor_q}) ? '0
                         : cursor_q - req_i.step[POS_W-1:0];
            end
            CMD_RIGHT: begin
              cursor_d = (req_i.step >= {2'b00, dist_to_end}) ? len_q
                         : cursor_q + req_i.step[POS_W-1:0];
            end
            CMD_TYPE: begin
              if (len_q >= CapPos) begin
                rsp_d.full_flag = 1'b1;
              end else begin
                chain_ctrl.op = OP_INSERT;
                cursor_d      = cursor_q + POS_W'(1);
                len_d         = len_q + POS_W'(1);
              end
            end
            CMD_BACKSPACE: begin
              if (cursor_q != '0) begin
                chain_ctrl.op = OP_DELETE;
                cursor_d      = cursor_q - POS_W'(1);
                len_d         = len_q - POS_W'(1);
              end
            end
            CMD_HOME: cursor_d = '0;
            CMD_END:  cursor_d = len_q;
            CMD_PRINT: begin
              state_d = ST_PRINT;
              pos_d   = '0;
              bar_d   = 1'b0;
            end
            default: ;
          endcase
          if (req_i.cmd != CMD_PRINT) begin
            valid_d          = 1'b1;
            rsp_d.out_byte   = '0;
            rsp_d.last       = 1'b1;
            rsp_d.cursor_now = cursor_d;
            rsp_d.length_now = len_d;
          end
        end
      end
      ST_PRINT: begin
        valid_d          = 1'b1;
        rsp_d.last       = 1'b0;
        rsp_d.cursor_now = cursor_q;
        rsp_d.length_now = len_q;
        rsp_d.full_flag  = 1'b0;
        if (pos_q == cursor_q && !bar_q) begin
          rsp_d.out_byte = BAR_BYTE;
          bar_d          = 1'b1;
        end else if (pos_q < len_q) begin
          // Take the head byte and rotate the text one place left.
          rsp_d.out_byte = head_byte;
          chain_ctrl.op  = OP_ROTATE;
          pos_d          = pos_q + POS_W'(1);
        end else begin
          rsp_d.out_byte = NL_BYTE;
          rsp_d.last     = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cursor_q <= '0;
      len_q    <= '0;
      pos_q    <= '0;
      bar_q    <= 1'b0;
      valid_q  <= 1'b0;
      rsp_q    <= '0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      bar_q    <= bar_d;
      valid_q  <= valid_d;
      rsp_q    <= rsp_d;
    end
  end

  assign busy    = (state_q == ST_PRINT);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  // The cursor never passes the end of the text.
  a_cursor_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= len_q)
    else $error("cursor beyond text length");

  // The text never grows past the cell count.
  a_len_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CapPos)
    else $error("text length beyond capacity");

  // An edit request answers with a single final result in the next cycle.
  a_edit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.cmd != CMD_PRINT) |=> (valid_o && rsp_o.last))
    else $error("edit request gave no final result");

  // Every print cycle produces a result.
  a_print_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRINT) |=> valid_o)
    else $error("print stream has a gap");

  // Once the print index has passed the cursor, the bar has been sent.
  a_bar_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRINT && pos_q > cursor_q) |-> bar_q)
    else $error("cursor bar skipped");

endmodule

>>> rtl/core/led_cell.sv
`timescale 1ns / 1ps
// One byte cell of the text chain.
// Depends on led_pkg for the select code and byte width.
module led_cell (
  input  logic                      clk_i,
  input  led_pkg::cell_sel_e        sel_i,
  input  logic [led_pkg::BYTE_W-1:0] left_i,
  input  logic [led_pkg::BYTE_W-1:0] right_i,
  input  logic [led_pkg::BYTE_W-1:0] char_i,
  output logic [led_pkg::BYTE_W-1:0] data_o
);
  import led_pkg::*;

  logic [BYTE_W-1:0] data_d, data_q;

  always_comb begin
    case (sel_i)
      SEL_LEFT:  data_d = left_i;
      SEL_RIGHT: data_d = right_i;
      SEL_LOAD:  data_d = char_i;
      default:   data_d = data_q;
    endcase
  end

  // Text bytes carry no reset; an entry is read only after it was written.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> rtl/core/led_chain.sv
`timescale 1ns / 1ps
// Row of byte cells with the per-cell shift selection for insert, delete
// and print rotation. Depends on led_pkg and led_cell.
module led_chain (
  input  logic                       clk_i,
  input  led_pkg::chain_ctrl_t       ctrl_i,
  output logic [led_pkg::BYTE_W-1:0] head_o
);
  import led_pkg::*;

  logic [BYTE_W-1:0] cell_data [CAPACITY];

  assign head_o = cell_data[0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [POS_W-1:0] Idx   = POS_W'(i);
    localparam logic [POS_W-1:0] IdxP1 = POS_W'(i + 1);

    cell_sel_e         sel;
    logic [BYTE_W-1:0] left_in;
    logic [BYTE_W-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid
      assign left_in = cell_data[i-1];
    end

    // The last text byte wraps to the head during print rotation.
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = cell_data[0];
    end else begin : g_inner
      assign right_in = (IdxP1 == ctrl_i.len) ? cell_data[0] : cell_data[i+1];
    end

    always_comb begin
      sel = SEL_HOLD;
      case (ctrl_i.op)
        OP_INSERT: begin
          if (Idx == ctrl_i.cursor) begin
            sel = SEL_LOAD;
          end else if (Idx > ctrl_i.cursor && Idx <= ctrl_i.len) begin
            sel = SEL_LEFT;
          end
        end
        OP_DELETE: begin
          if (IdxP1 >= ctrl_i.cursor && IdxP1 < ctrl_i.len) begin
            sel = SEL_RIGHT;
          end
        end
        OP_ROTATE: begin
          if (Idx < ctrl_i.len) begin
            sel = SEL_RIGHT;
          end
        end
        default: sel = SEL_HOLD;
      endcase
    end

    led_cell u_cell (
      .clk_i   (clk_i),
      .sel_i   (sel),
      .left_i  (left_in),
      .right_i (right_in),
      .char_i  (ctrl_i.ch),
      .data_o  (cell_data[i])
    );
  end

endmodule
